[design/gpg_pkg.sv]
// ----------------------------------------------------------------------------
// gpg_pkg: shared types, codes and helpers of the gradient pixel generator
// Register map codes, pattern codes, the configuration record and the
// image-size helpers used by both the distance and the ramp sections.
// ----------------------------------------------------------------------------
package gpg_pkg;

	localparam int MAX_DIM = 4096;
	localparam int DIM_W   = 13;
	localparam int COORD_W = 12;
	localparam int COL_W   = 24;
	localparam int APB_AW  = 5;
	localparam int APB_DW  = 32;

	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_FROM_COLOR   = 3'd0;
	localparam reg_idx_t REG_TO_COLOR     = 3'd1;
	localparam reg_idx_t REG_SIZE_PERCENT = 3'd2;
	localparam reg_idx_t REG_SOFTNESS     = 3'd3;
	localparam reg_idx_t REG_STRETCH      = 3'd4;
	localparam reg_idx_t REG_PATTERN      = 3'd5;
	localparam reg_idx_t REG_IMAGE_WIDTH  = 3'd6;
	localparam reg_idx_t REG_IMAGE_HEIGHT = 3'd7;

	typedef logic [2:0] pattern_t;
	localparam pattern_t PAT_HFWD    = 3'd0;
	localparam pattern_t PAT_HREV    = 3'd1;
	localparam pattern_t PAT_VFWD    = 3'd2;
	localparam pattern_t PAT_VREV    = 3'd3;
	localparam pattern_t PAT_RECT    = 3'd4;
	localparam pattern_t PAT_CIRCLE  = 3'd5;
	localparam pattern_t PAT_DIAMOND = 3'd6;

	typedef struct packed {
		logic [COL_W-1:0] from_color;
		logic [COL_W-1:0] to_color;
		logic [6:0]       size_percent;
		logic [6:0]       softness;
		logic             stretch;
		pattern_t         pattern;
		logic [DIM_W-1:0] image_width;
		logic [DIM_W-1:0] image_height;
	} cfg_t;

	// x/100 == (x * RECIP_100) >> RECIP_SHIFT for every x below 2^20
	localparam logic [20:0] RECIP_100   = 21'd1342178;
	localparam int          RECIP_SHIFT = 27;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v < DIM_W'(2)) begin
			r = DIM_W'(2);
		end else if (v > DIM_W'(MAX_DIM)) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic is_curtain(input pattern_t p);
		return (p == PAT_HFWD) || (p == PAT_HREV) || (p == PAT_VFWD) || (p == PAT_VREV);
	endfunction

	function automatic logic is_vertical(input pattern_t p);
		return (p == PAT_VFWD) || (p == PAT_VREV);
	endfunction

	// maximum distance of the ramp for the current pattern and image size
	function automatic logic [COORD_W-1:0] ramp_max(input cfg_t c);
		logic [DIM_W-1:0]   w;
		logic [DIM_W-1:0]   h;
		logic [COORD_W-1:0] r;
		w = clamp_dim(c.image_width);
		h = clamp_dim(c.image_height);
		if (is_curtain(c.pattern)) begin
			r = is_vertical(c.pattern) ? COORD_W'(h - DIM_W'(1)) : COORD_W'(w - DIM_W'(1));
		end else begin
			r = (w[DIM_W-1:1] < h[DIM_W-1:1]) ? w[DIM_W-1:1] : h[DIM_W-1:1];
		end
		return r;
	endfunction

endpackage

[design/gpg_if.sv]
// ----------------------------------------------------------------------------
// gpg_if: item channels of the gradient pixel generator
// Pixel coordinate channel in, pixel colour channel out, valid/ready.
// ----------------------------------------------------------------------------
interface gpg_pix_if;
	logic        valid;
	logic        ready;
	logic [11:0] pixel_x;
	logic [11:0] pixel_y;

	modport source (output valid, output pixel_x, output pixel_y, input ready);
	modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface gpg_rgb_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

[design/gradient_pixel_generator.sv]
// ----------------------------------------------------------------------------
// gradient_pixel_generator: two-colour gradient fill, one pixel per clock
// Top level: configuration registers, distance and ramp pipelines, output
// register with a skid entry.
// ----------------------------------------------------------------------------
// The block takes one pixel coordinate per clock while the colour side keeps
// taking; throughput is then one item per clock. The path holds three
// bit-per-stage units: the 12-stage aspect divider and the 13-stage square
// root in the distance pipeline and the 8-stage blend divider in the ramp
// pipeline, besides the stages of offsets, products and selection and the
// output register. Ramp limits are rebuilt from the registers after any
// write, through m_q and sn_q, s_q, ln_q, l_q and r_q, well before an item
// can reach them, so a pixel may be sent straight after a configuration
// write. When the colour side stalls, one further item lands in a skid
// entry and the pipeline then freezes as a whole, so nothing is lost or
// repeated. Registers sit at byte addresses 4*i (from colour, to colour,
// size, softness, stretch, pattern, width, height) and read back.
// ----------------------------------------------------------------------------
module gradient_pixel_generator
	import gpg_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	gpg_pix_if.sink           pixel,
	gpg_rgb_if.source         color
);

	cfg_t             cfg;
	logic             en;
	logic             d_valid, d_far;
	logic [DIM_W-1:0] d_dist;
	logic             p_valid;
	logic [COL_W-1:0] p_rgb;

	gpg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// distance of the pixel from the ramp origin
	gpg_dist u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.cfg       (cfg),
		.in_valid  (pixel.valid),
		.in_x      (pixel.pixel_x),
		.in_y      (pixel.pixel_y),
		.out_valid (d_valid),
		.out_d     (d_dist),
		.out_far   (d_far)
	);

	// distance to colour
	gpg_ramp u_ramp (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.cfg       (cfg),
		.in_valid  (d_valid),
		.in_d      (d_dist),
		.in_far    (d_far),
		.out_valid (p_valid),
		.out_rgb   (p_rgb)
	);

	// output register and skid entry
	logic             out_v_q, skid_v_q;
	logic [COL_W-1:0] out_rgb_q, skid_rgb_q;
	logic             pipe_out, out_free;

	// advance the whole pipeline unless the skid entry is holding an item
	assign en          = !skid_v_q;
	assign pixel.ready = en;
	assign pipe_out    = p_valid && en;
	assign out_free    = !out_v_q || color.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_free) begin
			// drain the skid entry first, else take the pipeline's item
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= pipe_out;
			end
		end else if (pipe_out) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_rgb_q <= skid_v_q ? skid_rgb_q : p_rgb;
		end else if (pipe_out) begin
			skid_rgb_q <= p_rgb;
		end
	end

	assign color.valid = out_v_q;
	assign color.red   = out_rgb_q[7:0];
	assign color.green = out_rgb_q[15:8];
	assign color.blue  = out_rgb_q[23:16];

endmodule

[design/gpg_regs.sv]
// ----------------------------------------------------------------------------
// gpg_regs: configuration register file
// APB write/read of the eight gradient settings.
// ----------------------------------------------------------------------------
module gpg_regs
	import gpg_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = paddr[APB_AW-1:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.from_color   <= '0;
			cfg_q.to_color     <= 24'hFFFFFF;
			cfg_q.size_percent <= 7'd100;
			cfg_q.softness     <= 7'd100;
			cfg_q.stretch      <= 1'b0;
			cfg_q.pattern      <= PAT_HFWD;
			cfg_q.image_width  <= 13'd256;
			cfg_q.image_height <= 13'd256;
		end else if (wr) begin
			case (idx)
				REG_FROM_COLOR:   cfg_q.from_color   <= pwdata[COL_W-1:0];
				REG_TO_COLOR:     cfg_q.to_color     <= pwdata[COL_W-1:0];
				REG_SIZE_PERCENT: cfg_q.size_percent <= pwdata[6:0];
				REG_SOFTNESS:     cfg_q.softness     <= pwdata[6:0];
				REG_STRETCH:      cfg_q.stretch      <= pwdata[0];
				REG_PATTERN:      cfg_q.pattern      <= pwdata[2:0];
				REG_IMAGE_WIDTH:  cfg_q.image_width  <= pwdata[DIM_W-1:0];
				REG_IMAGE_HEIGHT: cfg_q.image_height <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_FROM_COLOR:   prdata = APB_DW'(cfg_q.from_color);
			REG_TO_COLOR:     prdata = APB_DW'(cfg_q.to_color);
			REG_SIZE_PERCENT: prdata = APB_DW'(cfg_q.size_percent);
			REG_SOFTNESS:     prdata = APB_DW'(cfg_q.softness);
			REG_STRETCH:      prdata = APB_DW'(cfg_q.stretch);
			REG_PATTERN:      prdata = APB_DW'(cfg_q.pattern);
			REG_IMAGE_WIDTH:  prdata = APB_DW'(cfg_q.image_width);
			REG_IMAGE_HEIGHT: prdata = APB_DW'(cfg_q.image_height);
			default:          prdata = '0;
		endcase
	end

endmodule

[design/gpg_dist.sv]
// ----------------------------------------------------------------------------
// gpg_dist: distance pipeline
// Curtain coordinate or centred offsets, aspect scaling by a pipelined
// divider, then Chebyshev, Manhattan or pipelined integer square root.
// ----------------------------------------------------------------------------
module gpg_dist
	import gpg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  cfg_t               cfg,
	input  logic               in_valid,
	input  logic [COORD_W-1:0] in_x,
	input  logic [COORD_W-1:0] in_y,
	output logic               out_valid,
	output logic [DIM_W-1:0]   out_d,
	output logic               out_far
);

	localparam int DV_N = COORD_W;   // quotient bits of the aspect divider
	localparam int DV_W = 2*COORD_W; // numerator width
	localparam int SQ_N = DIM_W;     // root bits
	localparam int SQ_W = 2*DIM_W;   // radicand width

	logic [DIM_W-1:0]   w, h;
	logic [COORD_W-1:0] cx, cy, cs, cl, mc, coord, cc, dc, nx, ny;
	logic               short_x, curtain;

	always_comb begin
		w       = clamp_dim(cfg.image_width);
		h       = clamp_dim(cfg.image_height);
		cx      = w[DIM_W-1:1];
		cy      = h[DIM_W-1:1];
		curtain = is_curtain(cfg.pattern);
		mc      = is_vertical(cfg.pattern) ? COORD_W'(h - DIM_W'(1)) : COORD_W'(w - DIM_W'(1));
		coord   = is_vertical(cfg.pattern) ? in_y : in_x;
		cc      = (coord > mc) ? mc : coord;
		dc      = ((cfg.pattern == PAT_HREV) || (cfg.pattern == PAT_VREV)) ? mc - cc : cc;
		nx      = (in_x >= cx) ? in_x - cx : cx - in_x;
		ny      = (in_y >= cy) ? in_y - cy : cy - in_y;
		short_x = cx < cy;
		cs      = short_x ? cx : cy;
		cl      = short_x ? cy : cx;
	end

	// stage 1: offsets along the long and short half axes
	logic               v_s1;
	logic [COORD_W-1:0] dc_s1, nl_s1, ns_s1;

	// aspect divider stages
	logic               dv_v   [DV_N+1];
	logic [DV_W-1:0]    dv_rem [DV_N+1];
	logic [DV_N-1:0]    dv_q   [DV_N+1];
	logic [COORD_W-1:0] dv_nl  [DV_N+1];
	logic [COORD_W-1:0] dv_ns  [DV_N+1];
	logic [COORD_W-1:0] dv_dc  [DV_N+1];
	logic [DV_W-1:0]    dv_rem_n [DV_N];
	logic [DV_N-1:0]    dv_q_n   [DV_N];

	always_comb begin
		for (int i = 0; i < DV_N; i++) begin
			dv_rem_n[i] = dv_rem[i];
			dv_q_n[i]   = dv_q[i];
			if (dv_rem[i] >= (DV_W'(cl) << (DV_N-1-i))) begin
				dv_rem_n[i]          = dv_rem[i] - (DV_W'(cl) << (DV_N-1-i));
				dv_q_n[i][DV_N-1-i]  = 1'b1;
			end
		end
	end

	// squaring stage
	logic               v_s3;
	logic [DV_W-1:0]    sqa_s3, sqb_s3;
	logic [COORD_W-1:0] dmax_s3, dc_s3;
	logic [DIM_W-1:0]   dsum_s3;
	logic [COORD_W-1:0] nf;

	assign nf = cfg.stretch ? dv_q[DV_N] : dv_nl[DV_N];

	// root stages
	logic               sq_v    [SQ_N+1];
	logic [SQ_W-1:0]    sq_rad  [SQ_N+1];
	logic [SQ_W-1:0]    sq_res  [SQ_N+1];
	logic [COORD_W-1:0] sq_dmax [SQ_N+1];
	logic [DIM_W-1:0]   sq_dsum [SQ_N+1];
	logic [COORD_W-1:0] sq_dc   [SQ_N+1];
	logic [SQ_W-1:0]    sq_rad_n [SQ_N];
	logic [SQ_W-1:0]    sq_res_n [SQ_N];

	always_comb begin
		for (int i = 0; i < SQ_N; i++) begin
			if (sq_rad[i] >= sq_res[i] + (SQ_W'(1) << (2*(SQ_N-1-i)))) begin
				sq_rad_n[i] = sq_rad[i] - sq_res[i] - (SQ_W'(1) << (2*(SQ_N-1-i)));
				sq_res_n[i] = (sq_res[i] >> 1) + (SQ_W'(1) << (2*(SQ_N-1-i)));
			end else begin
				sq_rad_n[i] = sq_rad[i];
				sq_res_n[i] = sq_res[i] >> 1;
			end
		end
	end

	// final selection
	logic             v_s5, far_s5;
	logic [DIM_W-1:0] d_s5, d_sel;

	always_comb begin
		if (curtain) begin
			d_sel = DIM_W'(sq_dc[SQ_N]);
		end else if (cfg.pattern == PAT_CIRCLE) begin
			d_sel = sq_res[SQ_N][DIM_W-1:0];
		end else if (cfg.pattern == PAT_DIAMOND) begin
			d_sel = sq_dsum[SQ_N];
		end else begin
			d_sel = DIM_W'(sq_dmax[SQ_N]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s3 <= 1'b0;
			v_s5 <= 1'b0;
			for (int i = 0; i <= DV_N; i++) dv_v[i] <= 1'b0;
			for (int i = 0; i <= SQ_N; i++) sq_v[i] <= 1'b0;
		end else if (en) begin
			v_s1     <= in_valid;
			dv_v[0]  <= v_s1;
			for (int i = 0; i < DV_N; i++) dv_v[i+1] <= dv_v[i];
			v_s3     <= dv_v[DV_N];
			sq_v[0]  <= v_s3;
			for (int i = 0; i < SQ_N; i++) sq_v[i+1] <= sq_v[i];
			v_s5     <= sq_v[SQ_N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dc_s1 <= dc;
			nl_s1 <= short_x ? ny : nx;
			ns_s1 <= short_x ? nx : ny;

			dv_rem[0] <= DV_W'(nl_s1) * DV_W'(cs) + DV_W'(cl >> 1);
			dv_q[0]   <= '0;
			dv_nl[0]  <= (nl_s1 > cs) ? cs : nl_s1;
			dv_ns[0]  <= ns_s1;
			dv_dc[0]  <= dc_s1;
			for (int i = 0; i < DV_N; i++) begin
				dv_rem[i+1] <= dv_rem_n[i];
				dv_q[i+1]   <= dv_q_n[i];
				dv_nl[i+1]  <= dv_nl[i];
				dv_ns[i+1]  <= dv_ns[i];
				dv_dc[i+1]  <= dv_dc[i];
			end

			sqa_s3  <= DV_W'(nf) * DV_W'(nf);
			sqb_s3  <= DV_W'(dv_ns[DV_N]) * DV_W'(dv_ns[DV_N]);
			dmax_s3 <= (nf > dv_ns[DV_N]) ? nf : dv_ns[DV_N];
			dsum_s3 <= DIM_W'(nf) + DIM_W'(dv_ns[DV_N]);
			dc_s3   <= dv_dc[DV_N];

			sq_rad[0]  <= SQ_W'(sqa_s3) + SQ_W'(sqb_s3);
			sq_res[0]  <= '0;
			sq_dmax[0] <= dmax_s3;
			sq_dsum[0] <= dsum_s3;
			sq_dc[0]   <= dc_s3;
			for (int i = 0; i < SQ_N; i++) begin
				sq_rad[i+1]  <= sq_rad_n[i];
				sq_res[i+1]  <= sq_res_n[i];
				sq_dmax[i+1] <= sq_dmax[i];
				sq_dsum[i+1] <= sq_dsum[i];
				sq_dc[i+1]   <= sq_dc[i];
			end

			d_s5   <= d_sel;
			far_s5 <= !curtain && (d_sel > DIM_W'(cs));
		end
	end

	assign out_valid = v_s5;
	assign out_d     = d_s5;
	assign out_far   = far_s5;

endmodule

[design/gpg_ramp.sv]
// ----------------------------------------------------------------------------
// gpg_ramp: colour ramp pipeline
// Ramp limits from the settings, then per component a signed blend with a
// pipelined rounded division by the ramp length.
// ----------------------------------------------------------------------------
module gpg_ramp
	import gpg_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  cfg_t             cfg,
	input  logic             in_valid,
	input  logic [DIM_W-1:0] in_d,
	input  logic             in_far,
	output logic             out_valid,
	output logic [COL_W-1:0] out_rgb
);

	localparam int QB = 8;   // quotient bits
	localparam int NW = 21;  // numerator width, below 256 * ramp length
	localparam int NL = 3;   // colour components

	// ramp limits, recomputed every cycle from the settings
	logic [COORD_W-1:0]      m_q;
	logic [19:0]             sn_q;
	logic [DIM_W-1:0]        s_q, s_raw, r_q;
	logic signed [21:0]      ln_q, ps;
	logic [21:0]             lmag;
	logic [DIM_W:0]          lq;
	logic signed [DIM_W:0]   l_q;
	logic signed [DIM_W+1:0] rdiff;

	always_comb begin
		s_raw = DIM_W'((41'(sn_q) * 41'(RECIP_100)) >> RECIP_SHIFT);
		ps    = 22'sd100 - $signed(22'(cfg.softness));
		lmag  = ln_q[21] ? 22'(-ln_q) : 22'(ln_q);
		lq    = (DIM_W+1)'((41'(lmag[19:0]) * 41'(RECIP_100)) >> RECIP_SHIFT);
		rdiff = $signed({2'b00, s_q}) - $signed({l_q[DIM_W], l_q});
	end

	always_ff @(posedge clk) begin
		m_q  <= ramp_max(cfg);
		sn_q <= 20'(20'(ramp_max(cfg)) * 20'(cfg.size_percent)) + 20'd50;
		s_q  <= (s_raw == DIM_W'(m_q)) ? s_raw - DIM_W'(1) : s_raw;
		ln_q <= 22'($signed({9'b0, s_q}) * ps) + 22'sd50;
		l_q  <= ln_q[21] ? -$signed(lq) : $signed(lq);
		r_q  <= (rdiff == '0) ? DIM_W'(1) : rdiff[DIM_W-1:0];
	end

	// stage 1: zone of the distance
	logic                    v_t1, below_t1, above_t1;
	logic [DIM_W-1:0]        dl_t1;
	logic signed [DIM_W+1:0] dd, ls;

	assign dd = $signed({2'b00, in_d});
	assign ls = $signed({l_q[DIM_W], l_q});

	// stage 2: products
	logic      v_t2, below_t2, above_t2;
	logic [NW-1:0] prod_t2 [NL];
	logic          neg_t2  [NL];
	logic [7:0]    fc [NL];
	logic [7:0]    tc [NL];

	always_comb begin
		for (int k = 0; k < NL; k++) begin
			fc[k] = cfg.from_color[8*k +: 8];
			tc[k] = cfg.to_color[8*k +: 8];
		end
	end

	// divider stages
	logic          dv_v     [QB+1];
	logic          dv_below [QB+1];
	logic          dv_above [QB+1];
	logic [NW-1:0] dv_rem   [QB+1][NL];
	logic [QB-1:0] dv_q     [QB+1][NL];
	logic          dv_sg    [QB+1][NL];
	logic [NW-1:0] dv_rem_n [QB][NL];
	logic [QB-1:0] dv_q_n   [QB][NL];
	logic [NW-1:0] half;
	logic [NW-1:0] mag [NL];
	logic          sgn [NL];

	assign half = NW'(r_q >> 1);

	always_comb begin
		for (int k = 0; k < NL; k++) begin
			sgn[k] = neg_t2[k] && (prod_t2[k] > half);
			if (!neg_t2[k]) begin
				mag[k] = prod_t2[k] + half;
			end else if (sgn[k]) begin
				mag[k] = prod_t2[k] - half;
			end else begin
				mag[k] = half - prod_t2[k];
			end
		end
		for (int i = 0; i < QB; i++) begin
			for (int k = 0; k < NL; k++) begin
				dv_rem_n[i][k] = dv_rem[i][k];
				dv_q_n[i][k]   = dv_q[i][k];
				if (dv_rem[i][k] >= (NW'(r_q) << (QB-1-i))) begin
					dv_rem_n[i][k]        = dv_rem[i][k] - (NW'(r_q) << (QB-1-i));
					dv_q_n[i][k][QB-1-i]  = 1'b1;
				end
			end
		end
	end

	// final stage
	logic             v_t4;
	logic [COL_W-1:0] rgb_t4, rgb_n;

	always_comb begin
		for (int k = 0; k < NL; k++) begin
			if (dv_below[QB]) begin
				rgb_n[8*k +: 8] = fc[k];
			end else if (dv_above[QB]) begin
				rgb_n[8*k +: 8] = tc[k];
			end else if (dv_sg[QB][k]) begin
				rgb_n[8*k +: 8] = fc[k] - dv_q[QB][k];
			end else begin
				rgb_n[8*k +: 8] = fc[k] + dv_q[QB][k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_t1 <= 1'b0;
			v_t2 <= 1'b0;
			v_t4 <= 1'b0;
			for (int i = 0; i <= QB; i++) dv_v[i] <= 1'b0;
		end else if (en) begin
			v_t1    <= in_valid;
			v_t2    <= v_t1;
			dv_v[0] <= v_t2;
			for (int i = 0; i < QB; i++) dv_v[i+1] <= dv_v[i];
			v_t4    <= dv_v[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// a distance beyond the shape takes the end colour even inside the flat zone
			below_t1 <= !in_far && (dd <= ls);
			above_t1 <= in_far || (in_d > s_q);
			dl_t1    <= DIM_W'(dd - ls);

			below_t2 <= below_t1;
			above_t2 <= above_t1;
			for (int k = 0; k < NL; k++) begin
				neg_t2[k]  <= tc[k] < fc[k];
				prod_t2[k] <= NW'(((tc[k] < fc[k]) ? fc[k] - tc[k] : tc[k] - fc[k])) * NW'(dl_t1);
			end

			dv_below[0] <= below_t2;
			dv_above[0] <= above_t2;
			for (int k = 0; k < NL; k++) begin
				dv_rem[0][k] <= mag[k];
				dv_q[0][k]   <= '0;
				dv_sg[0][k]  <= sgn[k];
			end
			for (int i = 0; i < QB; i++) begin
				dv_below[i+1] <= dv_below[i];
				dv_above[i+1] <= dv_above[i];
				for (int k = 0; k < NL; k++) begin
					dv_rem[i+1][k] <= dv_rem_n[i][k];
					dv_q[i+1][k]   <= dv_q_n[i][k];
					dv_sg[i+1][k]  <= dv_sg[i][k];
				end
			end

			rgb_t4 <= rgb_n;
		end
	end

	assign out_valid = v_t4;
	assign out_rgb   = rgb_t4;

endmodule
